### hdl/hcnl_pkg.sv
// shared types and constants for the hall calibration nearest lookup
`timescale 1ns / 1ps
`default_nettype none

package hcnl_pkg;

	localparam int READING_W = 16;
	localparam int INDEX_W   = 6;
	localparam int SUM_W     = 2 * READING_W + 1;
	localparam int ROOT_W    = READING_W + 1;
	localparam int SQRT_STEPS = (SUM_W + 1) / 2;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_LIST    = 2'd1;
	localparam logic [1:0] OP_NEAREST = 2'd2;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [INDEX_W-1:0]   entry_index;
		logic [READING_W-1:0] reading_zero;
		logic [READING_W-1:0] reading_one;
		logic [READING_W-1:0] reading_two;
		logic [READING_W-1:0] reading_three;
		logic [1:0]           column_a;
		logic [1:0]           column_b;
		logic [READING_W-1:0] target_a;
		logic [READING_W-1:0] target_b;
	} query_beat_t;

	typedef struct packed {
		logic [READING_W-1:0] sorted_value;
		logic [INDEX_W-1:0]   nearest_index;
		logic                 last_result;
	} result_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIST_SCAN,
		ST_LIST_EMIT,
		ST_NEAR_SCAN,
		ST_NEAR_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mem_write;
		logic scan_start;
		logic list_clear;
		logic list_advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic list_done;
		logic list_last;
		logic near_done;
	} dp_status_t;

endpackage

`default_nettype wire

### hdl/hcnl_query_if.sv
// query channel: valid, ready and one operation beat
`timescale 1ns / 1ps
`default_nettype none

interface hcnl_query_if
	import hcnl_pkg::*;
();
	logic        valid;
	logic        ready;
	query_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/hcnl_result_if.sv
// result channel: valid, ready and one result beat
`timescale 1ns / 1ps
`default_nettype none

interface hcnl_result_if
	import hcnl_pkg::*;
();
	logic         valid;
	logic         ready;
	result_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/hall_calibration_nearest_lookup.sv
// top level of the hall calibration nearest lookup
//
//   port     dir   beat contents
//   query    in    opcode, entry index, four readings, two columns, two targets
//   result   out   sorted value, nearest index, last flag
//
// a write is stored from its beat and the next beat is taken straight after it
// each listed value takes a full scan of the store, one memory read a cycle
// a nearest query runs from its beat to its result beat as a scan of the store:
// one entry a cycle through the store read port, two squarers and a 17-stage
// square root pipeline
// one operation at a time; query ready is low from a list or nearest beat until
// its last result beat is taken, and a stalled result holds its value
// reset clears the sequencer and pipeline valids; the store is unset until written

`timescale 1ns / 1ps
`default_nettype none

module hall_calibration_nearest_lookup
	import hcnl_pkg::*;
#(
	parameter int ENTRY_COUNT = 63
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hcnl_query_if.sink     query,
	hcnl_result_if.source  result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	hcnl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.opcode    (query.payload.opcode),
		.in_ready  (query.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hcnl_datapath #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.query_beat  (query.payload),
		.status      (status),
		.result_beat (result.payload)
	);

endmodule

`default_nettype wire

### hdl/hcnl_isqrt.sv
// pipelined floor square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module hcnl_isqrt
	import hcnl_pkg::*;
#(
	parameter int TAG_W = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [TAG_W-1:0]  in_tag,
	input  wire logic [SUM_W-1:0]  in_value,
	output logic                   out_valid,
	output logic [TAG_W-1:0]       out_tag,
	output logic [ROOT_W-1:0]      out_root
);

	localparam int RW = SUM_W + 1;

	logic             vld_q  [1:SQRT_STEPS];
	logic [TAG_W-1:0] tag_q  [1:SQRT_STEPS];
	logic [SUM_W-1:0] rem_q  [1:SQRT_STEPS];
	logic [RW-1:0]    root_q [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic             vld_cur;
		logic [TAG_W-1:0] tag_cur;
		logic [SUM_W-1:0] rem_cur;
		logic [RW-1:0]    root_cur;
		logic [RW-1:0]    trial;
		logic             take;

		if (k == 0) begin : g_first
			assign vld_cur  = in_valid;
			assign tag_cur  = in_tag;
			assign rem_cur  = in_value;
			assign root_cur = '0;
		end else begin : g_next
			assign vld_cur  = vld_q[k];
			assign tag_cur  = tag_q[k];
			assign rem_cur  = rem_q[k];
			assign root_cur = root_q[k];
		end

		assign trial = root_cur + BIT;
		assign take  = {1'b0, rem_cur} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_cur;
			end
		end

		always_ff @(posedge clk) begin
			tag_q[k+1] <= tag_cur;
			if (take) begin
				rem_q[k+1]  <= rem_cur - trial[SUM_W-1:0];
				root_q[k+1] <= (root_cur >> 1) + BIT;
			end else begin
				rem_q[k+1]  <= rem_cur;
				root_q[k+1] <= root_cur >> 1;
			end
		end
	end

	assign out_valid = vld_q[SQRT_STEPS];
	assign out_tag   = tag_q[SQRT_STEPS];
	assign out_root  = root_q[SQRT_STEPS][ROOT_W-1:0];

endmodule

`default_nettype wire

### hdl/hcnl_datapath.sv
// calibration store, scan pipeline, list minimum tracker and nearest compare
`timescale 1ns / 1ps
`default_nettype none

module hcnl_datapath
	import hcnl_pkg::*;
#(
	parameter int ENTRY_COUNT = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ctrl_cmd_t    cmd,
	input  wire query_beat_t  query_beat,
	output dp_status_t        status,
	output result_beat_t      result_beat
);

	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int WIDE_W = 9;

	logic [4*READING_W-1:0] store_mem [ENTRY_COUNT];

	logic [1:0]           op_q;
	logic [1:0]           col_a_q;
	logic [1:0]           col_b_q;
	logic [READING_W-1:0] tgt_a_q;
	logic [READING_W-1:0] tgt_b_q;

	logic [IDX_W-1:0] addr_q;
	logic             issue_q;
	logic             addr_last;

	logic [WIDE_W-1:0] wr_wide;
	logic              wr_in_range;

	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [4*READING_W-1:0] data_s1;
	logic [READING_W-1:0]   val_a_s1;
	logic [READING_W-1:0]   val_b_s1;

	logic                 vld_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [READING_W-1:0] da_s2;
	logic [READING_W-1:0] db_s2;

	logic                   vld_s3;
	logic [IDX_W-1:0]       idx_s3;
	logic [2*READING_W-1:0] sqa_s3;
	logic [2*READING_W-1:0] sqb_s3;

	logic             vld_s4;
	logic [IDX_W-1:0] idx_s4;
	logic [SUM_W-1:0] sum_s4;

	logic              root_vld;
	logic [IDX_W-1:0]  root_idx;
	logic [ROOT_W-1:0] root_val;

	logic [READING_W-1:0] prev_q;
	logic                 prev_valid_q;
	logic [READING_W-1:0] min1_q;
	logic [READING_W-1:0] min2_q;
	logic                 found1_q;
	logic                 found2_q;
	logic                 qual;

	logic                best_found_q;
	logic [ROOT_W-1:0]   best_dist_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [WIDE_W-1:0]   best_wide;

	// operation fields held for the whole operation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= query_beat.opcode;
			col_a_q <= query_beat.column_a;
			col_b_q <= query_beat.column_b;
			tgt_a_q <= query_beat.target_a;
			tgt_b_q <= query_beat.target_b;
		end
	end

	assign wr_wide     = WIDE_W'(query_beat.entry_index);
	assign wr_in_range = wr_wide < WIDE_W'(ENTRY_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.mem_write && wr_in_range) begin
			store_mem[wr_wide[IDX_W-1:0]] <= {query_beat.reading_three, query_beat.reading_two,
				query_beat.reading_one, query_beat.reading_zero};
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= store_mem[addr_q];
	end

	// scan address sweeps every entry once per start
	assign addr_last = addr_q == IDX_W'(ENTRY_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			issue_q <= 1'b0;
		end else if (cmd.scan_start) begin
			addr_q  <= '0;
			issue_q <= 1'b1;
		end else if (issue_q) begin
			addr_q  <= addr_last ? '0 : addr_q + 1'b1;
			issue_q <= !addr_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			vld_s2 <= vld_s1 && (op_q == OP_NEAREST);
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign val_a_s1 = data_s1[col_a_q*READING_W +: READING_W];
	assign val_b_s1 = data_s1[col_b_q*READING_W +: READING_W];

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		da_s2  <= (val_a_s1 > tgt_a_q) ? val_a_s1 - tgt_a_q : tgt_a_q - val_a_s1;
		db_s2  <= (val_b_s1 > tgt_b_q) ? val_b_s1 - tgt_b_q : tgt_b_q - val_b_s1;
		idx_s3 <= idx_s2;
		sqa_s3 <= da_s2 * da_s2;
		sqb_s3 <= db_s2 * db_s2;
		idx_s4 <= idx_s3;
		sum_s4 <= SUM_W'(sqa_s3) + SUM_W'(sqb_s3);
	end

	hcnl_isqrt #(
		.TAG_W (IDX_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_tag    (idx_s4),
		.in_value  (sum_s4),
		.out_valid (root_vld),
		.out_tag   (root_idx),
		.out_root  (root_val)
	);

	// lowest and second lowest distinct values above the last one listed
	assign qual = !prev_valid_q || (val_a_s1 > prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			found1_q     <= 1'b0;
			found2_q     <= 1'b0;
		end else begin
			if (cmd.list_clear) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.list_advance) begin
				prev_valid_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				found1_q <= 1'b0;
				found2_q <= 1'b0;
			end else if (vld_s1 && (op_q == OP_LIST) && qual) begin
				if (!found1_q || (val_a_s1 < min1_q)) begin
					found1_q <= 1'b1;
					found2_q <= found1_q;
				end else if ((val_a_s1 != min1_q) && (!found2_q || (val_a_s1 < min2_q))) begin
					found2_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.list_advance) begin
			prev_q <= min1_q;
		end
		if (vld_s1 && (op_q == OP_LIST) && qual) begin
			if (!found1_q || (val_a_s1 < min1_q)) begin
				min1_q <= val_a_s1;
				min2_q <= min1_q;
			end else if ((val_a_s1 != min1_q) && (!found2_q || (val_a_s1 < min2_q))) begin
				min2_q <= val_a_s1;
			end
		end
	end

	// strict less-than keeps the lower index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			best_found_q <= 1'b0;
		end else if (root_vld) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (root_vld && (!best_found_q || (root_val < best_dist_q))) begin
			best_dist_q <= root_val;
			best_idx_q  <= root_idx;
		end
	end

	assign status.list_done = vld_s1 && (op_q == OP_LIST) && (idx_s1 == IDX_W'(ENTRY_COUNT - 1));
	assign status.list_last = !found2_q;
	assign status.near_done = root_vld && (root_idx == IDX_W'(ENTRY_COUNT - 1));

	assign best_wide = WIDE_W'(best_idx_q);

	always_comb begin
		if (op_q == OP_LIST) begin
			result_beat.sorted_value  = min1_q;
			result_beat.nearest_index = '0;
			result_beat.last_result   = !found2_q;
		end else begin
			result_beat.sorted_value  = '0;
			result_beat.nearest_index = best_wide[INDEX_W-1:0];
			result_beat.last_result   = 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/hcnl_ctrl.sv
// operation sequencer: accepts beats, starts scans, presents results
`timescale 1ns / 1ps
`default_nettype none

module hcnl_ctrl
	import hcnl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] opcode,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (opcode == OP_LIST)) begin
					state_next = ST_LIST_SCAN;
				end else if (in_valid && (opcode == OP_NEAREST)) begin
					state_next = ST_NEAR_SCAN;
				end
			end
			ST_LIST_SCAN: begin
				if (status.list_done) begin
					state_next = ST_LIST_EMIT;
				end
			end
			ST_LIST_EMIT: begin
				if (out_ready) begin
					state_next = status.list_last ? ST_IDLE : ST_LIST_SCAN;
				end
			end
			ST_NEAR_SCAN: begin
				if (status.near_done) begin
					state_next = ST_NEAR_EMIT;
				end
			end
			ST_NEAR_EMIT: begin
				if (out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		out_valid        = 1'b0;
		cmd              = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.load       = in_valid;
				cmd.mem_write  = in_valid && (opcode == OP_WRITE);
				cmd.list_clear = in_valid && (opcode == OP_LIST);
				cmd.scan_start = in_valid && ((opcode == OP_LIST) || (opcode == OP_NEAREST));
			end
			ST_LIST_EMIT: begin
				out_valid        = 1'b1;
				cmd.list_advance = out_ready && !status.list_last;
				cmd.scan_start   = out_ready && !status.list_last;
			end
			ST_NEAR_EMIT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire
